// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/vlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vlsc_pkg
// Types and constants of the lamp switch controller.
// ----------------------------------------------------------------------------
package vlsc_pkg;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ON   = 2'd1,
    EV_OFF  = 2'd2
  } ev_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W = 8;
  localparam int IVL_W = 16;
  localparam int NOW_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_IVL  = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd7;
  localparam logic [IVL_W-1:0] IVL_RST      = 16'd500;

  // switch slots
  localparam int SW_HAZ   = 0;
  localparam int SW_RIGHT = 1;
  localparam int SW_LEFT  = 2;
  localparam int SW_LOW   = 3;
  localparam int SW_HIGH  = 4;

  // lamp slots
  localparam int LP_RIGHT = 0;
  localparam int LP_LEFT  = 1;
  localparam int LP_LOW   = 2;
  localparam int LP_HIGH  = 3;
  localparam int LP_BEAT  = 4;

endpackage

// ===== rtl/vehicle_lamp_switch_controller_unit.sv =====
// ----------------------------------------------------------------------------
// vehicle_lamp_switch_controller_unit
// Debounces five active-low switches and drives turn, hazard, beam and
// heartbeat lamps with per-switch on/off display events.
// ----------------------------------------------------------------------------
// Takes one switch scan per clock while the output is not stalled and returns
// one result per scan. A scan sits in an input register, the whole update runs
// in one combinational pass, and the result lands in an output register; the
// rate is set by that single pass through the switch state. A stalled output
// holds the pipe without losing a scan. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while no scan is in flight; the block does
// not enforce this, and there is no clearing pass after reset.
module vehicle_lamp_switch_controller_unit #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_hazard_switch_n,
  input  logic                           in_right_switch_n,
  input  logic                           in_left_switch_n,
  input  logic                           in_low_beam_switch_n,
  input  logic                           in_high_beam_switch_n,
  input  logic [vlsc_pkg::NOW_W-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_right_lamp,
  output logic                           out_left_lamp,
  output logic                           out_low_beam_lamp,
  output logic                           out_high_beam_lamp,
  output logic                           out_heartbeat_led,
  output logic [1:0]                     out_hazard_event,
  output logic [1:0]                     out_right_event,
  output logic [1:0]                     out_left_event,
  output logic [1:0]                     out_low_beam_event,
  output logic [1:0]                     out_high_beam_event,
  input  logic                           cfg_we,
  input  logic [vlsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vlsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam int CMP_W = (COUNT_BITS > vlsc_pkg::DEB_W) ? COUNT_BITS : vlsc_pkg::DEB_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [TIME_BITS-1:0]  tm_t;

  // configuration
  logic [vlsc_pkg::DEB_W-1:0] deb_r;
  logic [vlsc_pkg::IVL_W-1:0] blink_ivl_r;
  logic [vlsc_pkg::IVL_W-1:0] beat_ivl_r;

  // input stage
  logic                       s1_valid_r;
  logic [4:0]                 sw_n_r;
  logic [vlsc_pkg::NOW_W-1:0] now_r;

  // switch state
  cnt_t       cnt_r   [5];
  cnt_t       cnt_nxt [5];
  logic [4:0] ann_r, ann_nxt;
  logic       haz_act_r, haz_act_nxt;
  tm_t        mark_r   [3];
  tm_t        mark_nxt [3];
  tm_t        beat_mark_r, beat_mark_nxt;
  logic [4:0] lamp_r, lamp_nxt;
  vlsc_pkg::ev_t ev_nxt [5];

  // output stage
  logic          out_valid_r;
  logic [4:0]    out_lamp_r;
  vlsc_pkg::ev_t out_ev_r [5];

  logic [4:0] pressed;
  tm_t        now_tm;
  logic       s1_adv;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == COUNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic reached(input cnt_t c, input logic [vlsc_pkg::DEB_W-1:0] d);
    reached = CMP_W'(c) >= CMP_W'(d);
  endfunction

  function automatic logic at_deb(input cnt_t c, input logic [vlsc_pkg::DEB_W-1:0] d);
    at_deb = CMP_W'(c) == CMP_W'(d);
  endfunction

  function automatic logic time_up(input tm_t now, input tm_t mark,
                                   input logic [vlsc_pkg::IVL_W-1:0] ivl);
    tm_t diff;
    diff = now - mark;
    time_up = diff >= TIME_BITS'(ivl);
  endfunction

  assign pressed  = ~sw_n_r;
  assign now_tm   = TIME_BITS'(now_r);
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    cnt_nxt       = cnt_r;
    ann_nxt       = ann_r;
    haz_act_nxt   = haz_act_r;
    mark_nxt      = mark_r;
    beat_mark_nxt = beat_mark_r;
    lamp_nxt      = lamp_r;
    for (int i = 0; i < 5; i++) begin
      ev_nxt[i] = vlsc_pkg::EV_NONE;
    end

    // hazard
    if (pressed[vlsc_pkg::SW_HAZ]) begin
      cnt_nxt[vlsc_pkg::SW_HAZ] = sat_inc(cnt_r[vlsc_pkg::SW_HAZ]);
      if (reached(cnt_nxt[vlsc_pkg::SW_HAZ], deb_r)) begin
        haz_act_nxt = 1'b1;
        if (at_deb(cnt_nxt[vlsc_pkg::SW_HAZ], deb_r)) begin
          lamp_nxt[vlsc_pkg::LP_RIGHT] = 1'b1;
          lamp_nxt[vlsc_pkg::LP_LEFT]  = 1'b1;
        end
        if (time_up(now_tm, mark_r[0], blink_ivl_r)) begin
          lamp_nxt[vlsc_pkg::LP_RIGHT] = ~lamp_nxt[vlsc_pkg::LP_RIGHT];
          lamp_nxt[vlsc_pkg::LP_LEFT]  = ~lamp_nxt[vlsc_pkg::LP_LEFT];
          mark_nxt[0] = now_tm;
        end
        if (!ann_r[vlsc_pkg::SW_HAZ]) begin
          ev_nxt[vlsc_pkg::SW_HAZ]  = vlsc_pkg::EV_ON;
          ann_nxt[vlsc_pkg::SW_HAZ] = 1'b1;
        end
      end
    end else begin
      haz_act_nxt = 1'b0;
      cnt_nxt[vlsc_pkg::SW_HAZ] = '0;
      mark_nxt[0] = now_tm;
      if (ann_r[vlsc_pkg::SW_HAZ]) begin
        ev_nxt[vlsc_pkg::SW_HAZ]     = vlsc_pkg::EV_OFF;
        lamp_nxt[vlsc_pkg::LP_RIGHT] = 1'b0;
        lamp_nxt[vlsc_pkg::LP_LEFT]  = 1'b0;
        ann_nxt[vlsc_pkg::SW_HAZ]    = 1'b0;
      end
    end

    // turn signals: switch i, mark i, lamp i-1
    for (int i = vlsc_pkg::SW_RIGHT; i <= vlsc_pkg::SW_LEFT; i++) begin
      if (pressed[i] && !haz_act_nxt) begin
        cnt_nxt[i] = sat_inc(cnt_r[i]);
        if (reached(cnt_nxt[i], deb_r)) begin
          if (at_deb(cnt_nxt[i], deb_r)) begin
            lamp_nxt[i-1] = 1'b1;
          end
          if (time_up(now_tm, mark_r[i], blink_ivl_r)) begin
            lamp_nxt[i-1] = ~lamp_nxt[i-1];
            mark_nxt[i]   = now_tm;
          end
          if (!ann_r[i]) begin
            ev_nxt[i]  = vlsc_pkg::EV_ON;
            ann_nxt[i] = 1'b1;
          end
        end
      end else begin
        mark_nxt[i] = now_tm;
        cnt_nxt[i]  = '0;
        if (ann_r[i]) begin
          ev_nxt[i]     = vlsc_pkg::EV_OFF;
          lamp_nxt[i-1] = 1'b0;
          ann_nxt[i]    = 1'b0;
        end
      end
    end

    // beams: switch i, lamp i-1
    for (int i = vlsc_pkg::SW_LOW; i <= vlsc_pkg::SW_HIGH; i++) begin
      if (pressed[i]) begin
        cnt_nxt[i] = sat_inc(cnt_r[i]);
        if (reached(cnt_nxt[i], deb_r)) begin
          lamp_nxt[i-1] = 1'b1;
          if (!ann_r[i]) begin
            ev_nxt[i]  = vlsc_pkg::EV_ON;
            ann_nxt[i] = 1'b1;
          end
        end
      end else begin
        cnt_nxt[i]    = '0;
        lamp_nxt[i-1] = 1'b0;
        if (ann_r[i]) begin
          ev_nxt[i]  = vlsc_pkg::EV_OFF;
          ann_nxt[i] = 1'b0;
        end
      end
    end

    // heartbeat
    if (time_up(now_tm, beat_mark_r, beat_ivl_r)) begin
      lamp_nxt[vlsc_pkg::LP_BEAT] = ~lamp_r[vlsc_pkg::LP_BEAT];
      beat_mark_nxt = now_tm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= vlsc_pkg::DEBOUNCE_RST;
      blink_ivl_r <= vlsc_pkg::IVL_RST;
      beat_ivl_r  <= vlsc_pkg::IVL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vlsc_pkg::REG_DEBOUNCE:  deb_r       <= cfg_wdata[vlsc_pkg::DEB_W-1:0];
        vlsc_pkg::REG_BLINK_IVL: blink_ivl_r <= cfg_wdata[vlsc_pkg::IVL_W-1:0];
        vlsc_pkg::REG_BEAT_IVL:  beat_ivl_r  <= cfg_wdata[vlsc_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ann_r       <= '0;
      haz_act_r   <= 1'b0;
      beat_mark_r <= '0;
      lamp_r      <= '0;
      for (int i = 0; i < 5; i++) begin
        cnt_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        mark_r[i] <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        cnt_r       <= cnt_nxt;
        ann_r       <= ann_nxt;
        haz_act_r   <= haz_act_nxt;
        mark_r      <= mark_nxt;
        beat_mark_r <= beat_mark_nxt;
        lamp_r      <= lamp_nxt;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sw_n_r <= {in_high_beam_switch_n, in_low_beam_switch_n, in_left_switch_n,
                 in_right_switch_n, in_hazard_switch_n};
      now_r  <= in_now_ms;
    end
    if (s1_adv) begin
      out_lamp_r <= lamp_nxt;
      out_ev_r   <= ev_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_right_lamp      = out_lamp_r[vlsc_pkg::LP_RIGHT];
  assign out_left_lamp       = out_lamp_r[vlsc_pkg::LP_LEFT];
  assign out_low_beam_lamp   = out_lamp_r[vlsc_pkg::LP_LOW];
  assign out_high_beam_lamp  = out_lamp_r[vlsc_pkg::LP_HIGH];
  assign out_heartbeat_led   = out_lamp_r[vlsc_pkg::LP_BEAT];
  assign out_hazard_event    = out_ev_r[vlsc_pkg::SW_HAZ];
  assign out_right_event     = out_ev_r[vlsc_pkg::SW_RIGHT];
  assign out_left_event      = out_ev_r[vlsc_pkg::SW_LEFT];
  assign out_low_beam_event  = out_ev_r[vlsc_pkg::SW_LOW];
  assign out_high_beam_event = out_ev_r[vlsc_pkg::SW_HIGH];

  `ASSERT_IMPL(a_haz_blocks_turn, clk, rst_n, haz_act_r,
               !ann_r[vlsc_pkg::SW_RIGHT] && !ann_r[vlsc_pkg::SW_LEFT])
  `ASSERT_IMPL(a_low_lamp_tracks_ann, clk, rst_n, 1'b1,
               lamp_r[vlsc_pkg::LP_LOW] == ann_r[vlsc_pkg::SW_LOW])
  `ASSERT_IMPL(a_high_lamp_tracks_ann, clk, rst_n, 1'b1,
               lamp_r[vlsc_pkg::LP_HIGH] == ann_r[vlsc_pkg::SW_HIGH])
  `ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r)

endmodule

// ===== tb/sv/vehicle_lamp_switch_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vehicle_lamp_switch_controller_unit_tb
// Self-checking testbench for the lamp switch controller.
// ----------------------------------------------------------------------------
// Drives switch scans over a valid/ready channel and predicts every lamp and
// display-event result with an in-bench model of the debounce, hazard, turn,
// beam and heartbeat logic. Results are compared field by field in order.
// Covers reset defaults, directed turn/hazard/beam sequences, time wrap,
// register extremes (zero, saturating debounce, zero and maximum intervals,
// an unused register index), a long result stall, and long random traffic
// under three idle profiles.
// ----------------------------------------------------------------------------
module vehicle_lamp_switch_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W      = 8;
  localparam int PIPE_LATENCY = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 100;

  localparam logic [COUNT_W-1:0]             COUNT_MAX  = '1;
  localparam logic [vlsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int MK_HAZ   = 0;
  localparam int MK_RIGHT = 1;
  localparam int MK_LEFT  = 2;

  localparam logic [4:0] PR_NONE  = 5'b00000;
  localparam logic [4:0] PR_HAZ   = 5'b00001;
  localparam logic [4:0] PR_RIGHT = 5'b00010;
  localparam logic [4:0] PR_LEFT  = 5'b00100;
  localparam logic [4:0] PR_LOW   = 5'b01000;
  localparam logic [4:0] PR_HIGH  = 5'b10000;
  localparam logic [4:0] PR_ALL   = 5'b11111;

  typedef logic [vlsc_pkg::NOW_W-1:0]      ms_t;
  typedef logic [vlsc_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [vlsc_pkg::CFG_IDX_W-1:0]  cfg_idx_t;

  typedef struct packed {
    logic haz_n;
    logic right_n;
    logic left_n;
    logic low_n;
    logic high_n;
    ms_t  now;
  } switch_scan_t;

  typedef struct packed {
    logic          right_lamp;
    logic          left_lamp;
    logic          low_lamp;
    logic          high_lamp;
    logic          beat_led;
    vlsc_pkg::ev_t haz_ev;
    vlsc_pkg::ev_t right_ev;
    vlsc_pkg::ev_t left_ev;
    vlsc_pkg::ev_t low_ev;
    vlsc_pkg::ev_t high_ev;
  } lamp_result_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      in_hazard_switch_n = 1'b1;
  logic      in_right_switch_n = 1'b1;
  logic      in_left_switch_n = 1'b1;
  logic      in_low_beam_switch_n = 1'b1;
  logic      in_high_beam_switch_n = 1'b1;
  ms_t       in_now_ms = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_right_lamp;
  logic      out_left_lamp;
  logic      out_low_beam_lamp;
  logic      out_high_beam_lamp;
  logic      out_heartbeat_led;
  logic [1:0] out_hazard_event;
  logic [1:0] out_right_event;
  logic [1:0] out_left_event;
  logic [1:0] out_low_beam_event;
  logic [1:0] out_high_beam_event;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  // predicted switch state and configuration
  logic [COUNT_W-1:0]         press_cnt [5];
  logic                       announced [5];
  logic                       hazard_on;
  ms_t                        blink_mark [3];
  ms_t                        beat_mark;
  logic                       lamp [5];
  logic [vlsc_pkg::DEB_W-1:0] deb_cfg;
  logic [vlsc_pkg::IVL_W-1:0] blink_cfg;
  logic [vlsc_pkg::IVL_W-1:0] beat_cfg;

  lamp_result_t expected_lamps [$];

  int errors = 0;
  int scans_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  vehicle_lamp_switch_controller_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_hazard_switch_n    (in_hazard_switch_n),
    .in_right_switch_n     (in_right_switch_n),
    .in_left_switch_n      (in_left_switch_n),
    .in_low_beam_switch_n  (in_low_beam_switch_n),
    .in_high_beam_switch_n (in_high_beam_switch_n),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_right_lamp        (out_right_lamp),
    .out_left_lamp         (out_left_lamp),
    .out_low_beam_lamp     (out_low_beam_lamp),
    .out_high_beam_lamp    (out_high_beam_lamp),
    .out_heartbeat_led     (out_heartbeat_led),
    .out_hazard_event      (out_hazard_event),
    .out_right_event       (out_right_event),
    .out_left_event        (out_left_event),
    .out_low_beam_event    (out_low_beam_event),
    .out_high_beam_event   (out_high_beam_event),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    for (int i = 0; i < 5; i++) begin
      press_cnt[i] = '0;
      announced[i] = 1'b0;
      lamp[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      blink_mark[i] = '0;
    end
    hazard_on = 1'b0;
    beat_mark = '0;
    deb_cfg = vlsc_pkg::DEBOUNCE_RST;
    blink_cfg = vlsc_pkg::IVL_RST;
    beat_cfg = vlsc_pkg::IVL_RST;
  endfunction

  function automatic logic interval_elapsed(ms_t now, ms_t mark,
                                            logic [vlsc_pkg::IVL_W-1:0] ivl);
    ms_t diff;
    diff = now - mark;
    return diff >= vlsc_pkg::NOW_W'(ivl);
  endfunction

  function automatic void bump_count(int sw);
    if (press_cnt[sw] != COUNT_MAX) begin
      press_cnt[sw] = press_cnt[sw] + 1'b1;
    end
  endfunction

  function automatic vlsc_pkg::ev_t turn_step(int sw, int mk, int lp, logic pressed,
                                              ms_t now);
    vlsc_pkg::ev_t ev;
    ev = vlsc_pkg::EV_NONE;
    if (pressed && !hazard_on) begin
      bump_count(sw);
      if (press_cnt[sw] >= deb_cfg) begin
        if (press_cnt[sw] == deb_cfg) begin
          lamp[lp] = 1'b1;
        end
        if (interval_elapsed(now, blink_mark[mk], blink_cfg)) begin
          lamp[lp] = ~lamp[lp];
          blink_mark[mk] = now;
        end
        if (!announced[sw]) begin
          ev = vlsc_pkg::EV_ON;
          announced[sw] = 1'b1;
        end
      end
    end else begin
      blink_mark[mk] = now;
      press_cnt[sw] = '0;
      if (announced[sw]) begin
        ev = vlsc_pkg::EV_OFF;
        lamp[lp] = 1'b0;
        announced[sw] = 1'b0;
      end
    end
    return ev;
  endfunction

  function automatic vlsc_pkg::ev_t beam_step(int sw, int lp, logic pressed);
    vlsc_pkg::ev_t ev;
    ev = vlsc_pkg::EV_NONE;
    if (pressed) begin
      bump_count(sw);
      if (press_cnt[sw] >= deb_cfg) begin
        lamp[lp] = 1'b1;
        if (!announced[sw]) begin
          ev = vlsc_pkg::EV_ON;
          announced[sw] = 1'b1;
        end
      end
    end else begin
      press_cnt[sw] = '0;
      lamp[lp] = 1'b0;
      if (announced[sw]) begin
        ev = vlsc_pkg::EV_OFF;
        announced[sw] = 1'b0;
      end
    end
    return ev;
  endfunction

  function automatic lamp_result_t lamp_update(switch_scan_t s);
    lamp_result_t r;
    r.haz_ev = vlsc_pkg::EV_NONE;
    if (!s.haz_n) begin
      bump_count(vlsc_pkg::SW_HAZ);
      if (press_cnt[vlsc_pkg::SW_HAZ] >= deb_cfg) begin
        hazard_on = 1'b1;
        if (press_cnt[vlsc_pkg::SW_HAZ] == deb_cfg) begin
          lamp[vlsc_pkg::LP_RIGHT] = 1'b1;
          lamp[vlsc_pkg::LP_LEFT] = 1'b1;
        end
        if (interval_elapsed(s.now, blink_mark[MK_HAZ], blink_cfg)) begin
          lamp[vlsc_pkg::LP_RIGHT] = ~lamp[vlsc_pkg::LP_RIGHT];
          lamp[vlsc_pkg::LP_LEFT] = ~lamp[vlsc_pkg::LP_LEFT];
          blink_mark[MK_HAZ] = s.now;
        end
        if (!announced[vlsc_pkg::SW_HAZ]) begin
          r.haz_ev = vlsc_pkg::EV_ON;
          announced[vlsc_pkg::SW_HAZ] = 1'b1;
        end
      end
    end else begin
      hazard_on = 1'b0;
      press_cnt[vlsc_pkg::SW_HAZ] = '0;
      blink_mark[MK_HAZ] = s.now;
      if (announced[vlsc_pkg::SW_HAZ]) begin
        r.haz_ev = vlsc_pkg::EV_OFF;
        lamp[vlsc_pkg::LP_RIGHT] = 1'b0;
        lamp[vlsc_pkg::LP_LEFT] = 1'b0;
        announced[vlsc_pkg::SW_HAZ] = 1'b0;
      end
    end
    r.right_ev = turn_step(vlsc_pkg::SW_RIGHT, MK_RIGHT, vlsc_pkg::LP_RIGHT, !s.right_n,
                           s.now);
    r.left_ev = turn_step(vlsc_pkg::SW_LEFT, MK_LEFT, vlsc_pkg::LP_LEFT, !s.left_n, s.now);
    r.low_ev = beam_step(vlsc_pkg::SW_LOW, vlsc_pkg::LP_LOW, !s.low_n);
    r.high_ev = beam_step(vlsc_pkg::SW_HIGH, vlsc_pkg::LP_HIGH, !s.high_n);
    if (interval_elapsed(s.now, beat_mark, beat_cfg)) begin
      lamp[vlsc_pkg::LP_BEAT] = ~lamp[vlsc_pkg::LP_BEAT];
      beat_mark = s.now;
    end
    r.right_lamp = lamp[vlsc_pkg::LP_RIGHT];
    r.left_lamp = lamp[vlsc_pkg::LP_LEFT];
    r.low_lamp = lamp[vlsc_pkg::LP_LOW];
    r.high_lamp = lamp[vlsc_pkg::LP_HIGH];
    r.beat_led = lamp[vlsc_pkg::LP_BEAT];
    return r;
  endfunction

  function automatic cfg_data_t pick_interval();
    case ($urandom_range(9))
      0: return '0;
      1: return vlsc_pkg::CFG_DATA_W'(1);
      2: return '1;
      default: return vlsc_pkg::CFG_DATA_W'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic void check_field(string fname, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      end
    end
  endfunction

  task automatic send_scan(logic [4:0] pressed, ms_t now);
    switch_scan_t s;
    s.haz_n = ~pressed[vlsc_pkg::SW_HAZ];
    s.right_n = ~pressed[vlsc_pkg::SW_RIGHT];
    s.left_n = ~pressed[vlsc_pkg::SW_LEFT];
    s.low_n = ~pressed[vlsc_pkg::SW_LOW];
    s.high_n = ~pressed[vlsc_pkg::SW_HIGH];
    s.now = now;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hazard_switch_n <= s.haz_n;
    in_right_switch_n <= s.right_n;
    in_left_switch_n <= s.left_n;
    in_low_beam_switch_n <= s.low_n;
    in_high_beam_switch_n <= s.high_n;
    in_now_ms <= s.now;
    do @(posedge clk); while (!in_ready);
    expected_lamps.push_back(lamp_update(s));
    scans_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_lamps.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      vlsc_pkg::REG_DEBOUNCE:  deb_cfg = data[vlsc_pkg::DEB_W-1:0];
      vlsc_pkg::REG_BLINK_IVL: blink_cfg = data[vlsc_pkg::IVL_W-1:0];
      vlsc_pkg::REG_BEAT_IVL:  beat_cfg = data[vlsc_pkg::IVL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_lamps();
    // reset defaults: low beam after seven scans, heartbeat at 500 ms
    for (int i = 0; i < 8; i++) begin
      send_scan(PR_LOW, vlsc_pkg::NOW_W'(i * 100));
    end
    send_scan(PR_NONE, vlsc_pkg::NOW_W'(800));
    wait_drained();
    write_reg(vlsc_pkg::REG_DEBOUNCE, vlsc_pkg::CFG_DATA_W'(2));
    write_reg(vlsc_pkg::REG_BLINK_IVL, vlsc_pkg::CFG_DATA_W'(3));
    write_reg(vlsc_pkg::REG_BEAT_IVL, vlsc_pkg::CFG_DATA_W'(2));
    send_scan(PR_NONE, vlsc_pkg::NOW_W'(0));
    send_scan(PR_LOW | PR_HIGH, vlsc_pkg::NOW_W'(1));
    send_scan(PR_LOW | PR_HIGH, vlsc_pkg::NOW_W'(2));
    send_scan(PR_LOW, vlsc_pkg::NOW_W'(3));
    send_scan(PR_RIGHT | PR_LOW, vlsc_pkg::NOW_W'(4));
    send_scan(PR_RIGHT, vlsc_pkg::NOW_W'(5));
    send_scan(PR_RIGHT, vlsc_pkg::NOW_W'(6));
    send_scan(PR_RIGHT, vlsc_pkg::NOW_W'(9));
    send_scan(PR_RIGHT, vlsc_pkg::NOW_W'(12));
    send_scan(PR_RIGHT | PR_HAZ, vlsc_pkg::NOW_W'(13));
    send_scan(PR_RIGHT | PR_HAZ, vlsc_pkg::NOW_W'(14));
    send_scan(PR_RIGHT | PR_HAZ, vlsc_pkg::NOW_W'(20));
    send_scan(PR_LEFT | PR_HAZ, vlsc_pkg::NOW_W'(21));
    send_scan(PR_LEFT, vlsc_pkg::NOW_W'(22));
    send_scan(PR_LEFT, 32'hFFFF_FFFE);
    send_scan(PR_LEFT, 32'hFFFF_FFFF);
    send_scan(PR_LEFT, vlsc_pkg::NOW_W'(0));
    send_scan(PR_LEFT, vlsc_pkg::NOW_W'(2));
    send_scan(PR_NONE, vlsc_pkg::NOW_W'(3));
    send_scan(PR_ALL, 32'h8000_0000);
    send_scan(PR_ALL, 32'hFFFF_FFFF);
    send_scan(PR_ALL, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    ms_t now;
    write_reg(REG_UNUSED, 16'hA5C3);
    write_reg(vlsc_pkg::REG_DEBOUNCE, '0);
    write_reg(vlsc_pkg::REG_BLINK_IVL, '0);
    write_reg(vlsc_pkg::REG_BEAT_IVL, '0);
    now = $urandom;
    for (int i = 0; i < 16; i++) begin
      now = now + vlsc_pkg::NOW_W'(i % 2);
      send_scan((i < 8) ? (PR_RIGHT | PR_LOW) : (PR_HAZ | PR_LEFT | PR_HIGH), now);
    end
    send_scan(PR_NONE, now);
    wait_drained();
    // saturating debounce: the switch-on set repeats while held
    write_reg(vlsc_pkg::REG_DEBOUNCE, '1);
    write_reg(vlsc_pkg::REG_BLINK_IVL, '1);
    write_reg(vlsc_pkg::REG_BEAT_IVL, vlsc_pkg::CFG_DATA_W'(1));
    now = 32'hFFFF_0000;
    for (int i = 0; i < 516; i++) begin
      now = now + vlsc_pkg::NOW_W'(700);
      send_scan((i < 258) ? (PR_HAZ | PR_LOW) : (PR_RIGHT | PR_LEFT | PR_HIGH), now);
    end
    send_scan(PR_NONE, now);
    wait_drained();
    write_reg(vlsc_pkg::REG_DEBOUNCE, vlsc_pkg::CFG_DATA_W'(254));
    write_reg(vlsc_pkg::REG_BLINK_IVL, vlsc_pkg::CFG_DATA_W'(1));
    write_reg(vlsc_pkg::REG_BEAT_IVL, '1);
    for (int i = 0; i < 256; i++) begin
      now = now + vlsc_pkg::NOW_W'($urandom_range(0, 3));
      send_scan(PR_HAZ | PR_RIGHT | PR_LOW, now);
    end
    send_scan(PR_NONE, now);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int  saved_pct;
    ms_t now;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    now = $urandom;
    hold_left = 150;
    for (int i = 0; i < 40; i++) begin
      now = now + vlsc_pkg::NOW_W'($urandom_range(0, 200));
      send_scan(5'($urandom_range(31)), now);
    end
    send_idle_pct = saved_pct;
    wait_drained();
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    logic [4:0] held;
    logic [4:0] pressed;
    ms_t        now;
    int         bit_sel;
    held = PR_NONE;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(9))
        0: write_reg(vlsc_pkg::REG_DEBOUNCE, vlsc_pkg::CFG_DATA_W'(1));
        1: write_reg(vlsc_pkg::REG_DEBOUNCE, '0);
        2: write_reg(vlsc_pkg::REG_DEBOUNCE, vlsc_pkg::CFG_DATA_W'($urandom_range(7, 20)));
        default: write_reg(vlsc_pkg::REG_DEBOUNCE,
                           vlsc_pkg::CFG_DATA_W'($urandom_range(2, 6)));
      endcase
      write_reg(vlsc_pkg::REG_BLINK_IVL, pick_interval());
      write_reg(vlsc_pkg::REG_BEAT_IVL, pick_interval());
      now = $urandom;
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(11) == 0) begin
          bit_sel = $urandom_range(4);
          held[bit_sel] = ~held[bit_sel];
        end
        pressed = held;
        if ($urandom_range(24) == 0) begin
          bit_sel = $urandom_range(4);
          pressed[bit_sel] = ~pressed[bit_sel];
        end
        case ($urandom_range(19))
          0: now = $urandom;
          1: now = now + vlsc_pkg::NOW_W'($urandom_range(30000, 70000));
          2: ;
          default: now = now + vlsc_pkg::NOW_W'($urandom_range(1, 30));
        endcase
        send_scan(pressed, now);
      end
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    lamp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lamps.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result transfer with no scan outstanding", $time);
        end
      end else begin
        want = expected_lamps.pop_front();
        check_field("right_lamp", 2'(want.right_lamp), 2'(out_right_lamp));
        check_field("left_lamp", 2'(want.left_lamp), 2'(out_left_lamp));
        check_field("low_beam_lamp", 2'(want.low_lamp), 2'(out_low_beam_lamp));
        check_field("high_beam_lamp", 2'(want.high_lamp), 2'(out_high_beam_lamp));
        check_field("heartbeat_led", 2'(want.beat_led), 2'(out_heartbeat_led));
        check_field("hazard_event", want.haz_ev, out_hazard_event);
        check_field("right_event", want.right_ev, out_right_event);
        check_field("left_event", want.left_ev, out_left_event);
        check_field("low_beam_event", want.low_ev, out_low_beam_event);
        check_field("high_beam_event", want.high_ev, out_high_beam_event);
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_lamps.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    reset_model();
    send_idle_pct = 21;
    recv_idle_pct = 82;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lamps();
    test_register_extremes();
    test_random_traffic(4, 37);
    send_idle_pct = 82;
    recv_idle_pct = 21;
    test_backpressure();
    test_random_traffic(4, 37);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(4, 37);
    wait_drained();
    repeat (8 * PIPE_LATENCY) @(posedge clk);
    $display("Checked %0d of %0d scans across %0d register writes and three idle profiles,",
             results_checked, scans_sent, reg_writes);
    $display("including saturating debounce, zero intervals, time wrap and a long stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vlsc_pkg.sv
rtl/vehicle_lamp_switch_controller_unit.sv
tb/sv/vehicle_lamp_switch_controller_unit_tb.sv
